@@ sv/cluster_interrupt_distributor_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Cluster interrupt distributor assertion macros
// Shared property forms for the concurrent checks of the distributor.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_INTERRUPT_DISTRIBUTOR_UNIT_ASSERT_SVH
`define CLUSTER_INTERRUPT_DISTRIBUTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CLID_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("distributor assertion failed");

// Next-cycle implication.
`define CLID_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("distributor assertion failed");

`endif

@@ sv/clid_pkg.sv @@
// ----------------------------------------------------------------------------
// Cluster interrupt distributor package
// Sizes, codes, helper functions and the source-table request types.
// ----------------------------------------------------------------------------
`default_nettype none

package clid_pkg;

  localparam int MAX_HARTS      = 32;
  localparam int MAX_SEMAPHORES = 32;
  localparam int MAX_SOURCES    = 64;

  localparam int HART_AW = $clog2(MAX_HARTS);
  localparam int SEM_AW  = $clog2(MAX_SEMAPHORES);
  localparam int SRC_AW  = $clog2(MAX_SOURCES);

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 6;
  localparam int HARTS_W    = 6;
  localparam int SOURCES_W  = 7;
  localparam int GROUP_W    = 4;
  localparam int CMD_W      = 2;
  localparam int PRIV_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SEM_W      = 10;
  localparam int ID_W       = 16;

  localparam logic [SEM_W-1:0]  SEM_FREE  = 10'h3ff;
  localparam logic [DATA_W-1:0] IND_RESET = 32'h1;

  localparam logic [PRIV_W-1:0] PRIV_SUPER   = 2'd1;
  localparam logic [PRIV_W-1:0] PRIV_MACHINE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HARTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTER  = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LEVEL = 2'd2
  } cmd_t;

  typedef enum logic [GROUP_W-1:0] {
    GRP_CORE    = 4'd0,
    GRP_SEM     = 4'd1,
    GRP_ICI     = 4'd2,
    GRP_IND     = 4'd3,
    GRP_MASK    = 4'd4,
    GRP_HARTS   = 4'd5,
    GRP_SOURCES = 4'd6,
    GRP_SRW     = 4'd7
  } grp_t;

  typedef enum logic [1:0] {
    ROP_NONE  = 2'd0,
    ROP_IND   = 2'd1,
    ROP_MASK  = 2'd2,
    ROP_LEVEL = 2'd3
  } route_op_t;

  typedef struct packed {
    logic              valid;
    route_op_t         op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic              level;
    logic [DATA_W-1:0] full;
    logic              enable;
  } route_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] ind;
    logic [DATA_W-1:0] mask;
    logic              update;
    logic [DATA_W-1:0] delivered;
  } route_rsp_t;

  function automatic logic [HARTS_W-1:0] hart_count(input logic [HARTS_W-1:0] harts);
    logic [HARTS_W-1:0] n;
    n = (int'(harts) > MAX_HARTS) ? HARTS_W'(MAX_HARTS) : harts;
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] full_hart_mask(input logic [HARTS_W-1:0] harts);
    logic [HARTS_W-1:0] n;
    logic [DATA_W-1:0]  m;
    n = hart_count(harts);
    if (int'(n) >= DATA_W) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << n) - DATA_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ sv/clid_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/clid_route.sv @@
// ----------------------------------------------------------------------------
// Source routing tables
// Hart indicator, hart mask and delivered tables per external source, with
// the delivery recompute for the source touched by the current request.
// ----------------------------------------------------------------------------
`default_nettype none

module clid_route (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [clid_pkg::IDX_W-1:0] rd_addr,
  input  logic                       mask_reload,
  input  clid_pkg::route_req_t       req,
  output clid_pkg::route_rsp_t       rsp
);

  import clid_pkg::*;

  logic [DATA_W-1:0]      ind_q;
  logic [DATA_W-1:0]      mask_q;
  logic [DATA_W-1:0]      deliv_q;
  logic [MAX_SOURCES-1:0] ind_vld;
  logic [MAX_SOURCES-1:0] mask_vld;
  logic [MAX_SOURCES-1:0] deliv_vld;
  logic [MAX_SOURCES-1:0] levels;

  logic                   fwd_ind_v;
  logic                   fwd_mask_v;
  logic                   fwd_deliv_v;
  logic [SRC_AW-1:0]      fwd_ind_addr;
  logic [SRC_AW-1:0]      fwd_mask_addr;
  logic [SRC_AW-1:0]      fwd_deliv_addr;
  logic [DATA_W-1:0]      fwd_ind_data;
  logic [DATA_W-1:0]      fwd_mask_data;
  logic [DATA_W-1:0]      fwd_deliv_data;

  logic [SRC_AW-1:0]      addr;
  logic [DATA_W-1:0]      cur_ind;
  logic [DATA_W-1:0]      cur_mask;
  logic [DATA_W-1:0]      cur_deliv;
  logic [DATA_W-1:0]      data_full;
  logic [DATA_W-1:0]      new_ind;
  logic [DATA_W-1:0]      upd_mask;
  logic [DATA_W-1:0]      want;
  logic                   new_lvl;
  logic                   mask_ok;
  logic                   do_route;
  logic                   upd;
  logic                   ind_we;
  logic                   mask_we;
  logic                   deliv_we;

  clid_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SOURCES)) u_ind_ram (
    .clk   (clk),
    .we    (ind_we),
    .waddr (addr),
    .wdata (new_ind),
    .re    (rd_en),
    .raddr (rd_addr[SRC_AW-1:0]),
    .rdata (ind_q)
  );

  clid_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SOURCES)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (addr),
    .wdata (upd_mask),
    .re    (rd_en),
    .raddr (rd_addr[SRC_AW-1:0]),
    .rdata (mask_q)
  );

  clid_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SOURCES)) u_deliv_ram (
    .clk   (clk),
    .we    (deliv_we),
    .waddr (addr),
    .wdata (want),
    .re    (rd_en),
    .raddr (rd_addr[SRC_AW-1:0]),
    .rdata (deliv_q)
  );

  // A write from the previous request lands on the same edge as this
  // request's read, so that write is forwarded here.
  always_comb begin
    addr = req.idx[SRC_AW-1:0];
    if (fwd_ind_v && fwd_ind_addr == addr) begin
      cur_ind = fwd_ind_data;
    end else begin
      cur_ind = ind_vld[addr] ? ind_q : IND_RESET;
    end
    if (fwd_mask_v && fwd_mask_addr == addr) begin
      cur_mask = fwd_mask_data;
    end else begin
      cur_mask = mask_vld[addr] ? mask_q : req.full;
    end
    if (fwd_deliv_v && fwd_deliv_addr == addr) begin
      cur_deliv = fwd_deliv_data;
    end else begin
      cur_deliv = deliv_vld[addr] ? deliv_q : '0;
    end
    data_full = req.data & req.full;
    new_ind   = (req.op == ROP_IND) ? data_full : cur_ind;
    mask_ok   = (req.op == ROP_MASK) && (cur_mask == req.full || data_full == req.full);
    upd_mask  = mask_ok ? data_full : cur_mask;
    new_lvl   = (req.op == ROP_LEVEL) ? req.level : levels[addr];
    do_route  = req.enable && (req.op == ROP_IND || mask_ok || req.op == ROP_LEVEL);
    want      = new_lvl ? (new_ind & upd_mask & req.full) : '0;
    upd       = do_route && (want != cur_deliv);
    ind_we    = req.valid && (req.op == ROP_IND);
    mask_we   = req.valid && mask_ok;
    deliv_we  = req.valid && upd;
    rsp.ind       = cur_ind;
    rsp.mask      = cur_mask;
    rsp.update    = upd;
    rsp.delivered = want;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ind_vld     <= '0;
      mask_vld    <= '0;
      deliv_vld   <= '0;
      levels      <= '0;
      fwd_ind_v   <= 1'b0;
      fwd_mask_v  <= 1'b0;
      fwd_deliv_v <= 1'b0;
    end else begin
      fwd_ind_v   <= ind_we;
      fwd_mask_v  <= mask_we && !mask_reload;
      fwd_deliv_v <= deliv_we;
      if (ind_we) begin
        ind_vld[addr] <= 1'b1;
      end
      if (mask_reload) begin
        mask_vld <= '0;
      end else if (mask_we) begin
        mask_vld[addr] <= 1'b1;
      end
      if (deliv_we) begin
        deliv_vld[addr] <= 1'b1;
      end
      if (req.valid && req.op == ROP_LEVEL) begin
        levels[addr] <= req.level;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_ind_addr   <= addr;
    fwd_mask_addr  <= addr;
    fwd_deliv_addr <= addr;
    fwd_ind_data   <= new_ind;
    fwd_mask_data  <= upd_mask;
    fwd_deliv_data <= want;
  end

endmodule

`default_nettype wire

@@ sv/cluster_interrupt_distributor_unit.sv @@
// ----------------------------------------------------------------------------
// Cluster interrupt distributor
// Each request is captured into the stage registers when taken; its result is
// then registered into the output registers together with done.
// Throughput: one request per cycle while busy is low; the source tables are
// RAMs with one read and one write port, read as the request is taken and
// written at the following edge. Reset: all tables return to their reset
// values at once; busy is high while reset is held and drops at the edge
// after its release. The result receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cluster_interrupt_distributor_unit_assert.svh"

module cluster_interrupt_distributor_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [clid_pkg::CMD_W-1:0]      command,
  input  logic [clid_pkg::GROUP_W-1:0]    reg_group,
  input  logic [clid_pkg::IDX_W-1:0]      item_index,
  input  logic [clid_pkg::DATA_W-1:0]     write_data,
  input  logic [clid_pkg::PRIV_W-1:0]     priv_level,
  input  logic                            source_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clid_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            done,
  output logic [clid_pkg::DATA_W-1:0]     read_data,
  output logic [clid_pkg::DATA_W-1:0]     soft_irq_lines,
  output logic                            ext_update,
  output logic [clid_pkg::IDX_W-1:0]      ext_source,
  output logic [clid_pkg::DATA_W-1:0]     ext_delivered,
  output logic                            access_denied,
  output logic                            bad_register
);

  import clid_pkg::*;

  logic [HARTS_W-1:0]   active_harts;
  logic [SOURCES_W-1:0] active_sources;
  logic                 router_present;

  logic                 s_valid;
  logic [CMD_W-1:0]     s_cmd;
  logic [GROUP_W-1:0]   s_group;
  logic [IDX_W-1:0]     s_idx;
  logic [DATA_W-1:0]    s_data;
  logic [PRIV_W-1:0]    s_priv;
  logic                 s_lvl;

  logic [DATA_W-1:0]    core_status [MAX_HARTS];
  logic [MAX_HARTS-1:0] core_nz;
  logic [SEM_W-1:0]     semaphores [MAX_SEMAPHORES];
  logic                 srw_lock;

  logic                 accept;
  logic                 cfg_write;
  logic                 mask_reload;
  logic [DATA_W-1:0]    full;
  logic [HARTS_W-1:0]   n_harts;
  logic [ID_W-1:0]      snd;
  logic [ID_W-1:0]      rcv;
  logic                 ici_ok;
  logic                 is_read;
  logic                 is_write;
  logic                 allowed;
  logic                 denied;
  logic                 bus_ok;
  logic                 hart_ok;
  logic                 sem_ok;
  logic                 src_ok;
  logic                 route_en;
  logic [HART_AW-1:0]   cs_addr;
  logic [DATA_W-1:0]    cs_cur;
  logic [DATA_W-1:0]    cs_new;
  logic                 cs_we;
  logic [SEM_AW-1:0]    sem_addr;
  logic [SEM_W-1:0]     sem_cur;
  logic [SEM_W-1:0]     sem_new;
  logic                 sem_we;
  logic                 srw_we;
  logic                 bad;
  logic [DATA_W-1:0]    rd_val;
  logic [MAX_HARTS-1:0] nz_next;
  route_op_t            op;
  route_req_t           req;
  route_rsp_t           rsp;

  assign accept      = start && !busy;
  assign cfg_ready   = !busy;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign mask_reload = cfg_write && (cfg_index == CFG_HARTS);

  clid_route u_route (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (accept),
    .rd_addr     (item_index),
    .mask_reload (mask_reload),
    .req         (req),
    .rsp         (rsp)
  );

  always_comb begin
    full     = full_hart_mask(active_harts);
    n_harts  = hart_count(active_harts);
    snd      = s_data[DATA_W-1:ID_W];
    rcv      = s_data[ID_W-1:0];
    ici_ok   = (snd < ID_W'(n_harts)) && (rcv < ID_W'(n_harts));
    is_read  = (s_cmd == CMD_READ);
    is_write = (s_cmd == CMD_WRITE);
    allowed  = (s_priv == PRIV_MACHINE) ||
               ((s_group != GRP_SRW) && (s_priv == PRIV_SUPER) && !srw_lock);
    denied   = (is_read || is_write) && !allowed;
    bus_ok   = (is_read || is_write) && allowed;
    hart_ok  = int'(s_idx) < MAX_HARTS;
    sem_ok   = int'(s_idx) < MAX_SEMAPHORES;
    src_ok   = int'(s_idx) < MAX_SOURCES;
    route_en = router_present && (SOURCES_W'(s_idx) < active_sources) && src_ok;
    cs_addr  = (is_write && s_group == GRP_ICI) ? rcv[HART_AW-1:0] : s_idx[HART_AW-1:0];
    cs_cur   = core_status[cs_addr];
    sem_addr = s_idx[SEM_AW-1:0];
    sem_cur  = semaphores[sem_addr];
    sem_new  = s_data[SEM_W-1:0];
    rd_val   = '0;
    bad      = 1'b0;
    cs_we    = 1'b0;
    cs_new   = cs_cur;
    sem_we   = 1'b0;
    srw_we   = 1'b0;
    op       = ROP_NONE;
    if (bus_ok) begin
      unique case (grp_t'(s_group))
        GRP_CORE: begin
          if (!hart_ok) begin
            bad = 1'b1;
          end else if (is_read) begin
            rd_val = cs_cur;
          end else begin
            cs_we  = 1'b1;
            cs_new = cs_cur & ~s_data;
          end
        end
        GRP_SEM: begin
          if (!sem_ok) begin
            bad = 1'b1;
          end else if (is_read) begin
            rd_val = DATA_W'(sem_cur);
          end else if (sem_new == SEM_FREE || sem_cur == SEM_FREE || sem_cur == sem_new) begin
            sem_we = 1'b1;
          end
        end
        GRP_ICI: begin
          if (is_read) begin
            bad = 1'b1;
          end else if (ici_ok) begin
            cs_we  = 1'b1;
            cs_new = cs_cur | (DATA_W'(1) << snd[HART_AW-1:0]);
          end
        end
        GRP_IND: begin
          if (!src_ok) begin
            bad = 1'b1;
          end else if (is_read) begin
            rd_val = rsp.ind;
          end else begin
            op = ROP_IND;
          end
        end
        GRP_MASK: begin
          if (!src_ok) begin
            bad = 1'b1;
          end else if (is_read) begin
            rd_val = rsp.mask;
          end else begin
            op = ROP_MASK;
          end
        end
        GRP_HARTS: begin
          if (is_read) begin
            rd_val = DATA_W'(active_harts);
          end else begin
            bad = 1'b1;
          end
        end
        GRP_SOURCES: begin
          if (is_read) begin
            rd_val = DATA_W'(active_sources);
          end else begin
            bad = 1'b1;
          end
        end
        GRP_SRW: begin
          if (is_read) begin
            rd_val = DATA_W'(srw_lock);
          end else begin
            srw_we = 1'b1;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end else if (s_cmd == CMD_LEVEL && route_en) begin
      op = ROP_LEVEL;
    end
    nz_next = core_nz;
    if (cs_we) begin
      nz_next[cs_addr] = |cs_new;
    end
    req.valid  = s_valid;
    req.op     = op;
    req.idx    = s_idx;
    req.data   = s_data;
    req.level  = s_lvl;
    req.full   = full;
    req.enable = route_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b1;
      s_valid        <= 1'b0;
      done           <= 1'b0;
      active_harts   <= HARTS_W'(1);
      active_sources <= '0;
      router_present <= 1'b1;
      core_nz        <= '0;
      srw_lock       <= 1'b0;
      for (int i = 0; i < MAX_HARTS; i++) begin
        core_status[i] <= '0;
      end
      for (int i = 0; i < MAX_SEMAPHORES; i++) begin
        semaphores[i] <= SEM_FREE;
      end
    end else begin
      busy    <= 1'b0;
      s_valid <= accept;
      done    <= s_valid;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_HARTS:   active_harts   <= cfg_data[HARTS_W-1:0];
          CFG_SOURCES: active_sources <= cfg_data[SOURCES_W-1:0];
          CFG_ROUTER:  router_present <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_valid) begin
        core_nz <= nz_next;
        if (cs_we) begin
          core_status[cs_addr] <= cs_new;
        end
        if (sem_we) begin
          semaphores[sem_addr] <= sem_new;
        end
        if (srw_we) begin
          srw_lock <= s_data[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd   <= command;
      s_group <= reg_group;
      s_idx   <= item_index;
      s_data  <= write_data;
      s_priv  <= priv_level;
      s_lvl   <= source_level;
    end
    if (s_valid) begin
      read_data      <= rd_val;
      soft_irq_lines <= nz_next & full;
      ext_update     <= rsp.update;
      ext_source     <= rsp.update ? s_idx : '0;
      ext_delivered  <= rsp.update ? rsp.delivered : '0;
      access_denied  <= denied;
      bad_register   <= bad;
    end
  end

  `CLID_ASSERT_NEXT(a_stage_to_result, clk, rst, s_valid, done)
  `CLID_ASSERT_NOW(a_single_error, clk, rst, done, !(access_denied && bad_register))
  `CLID_ASSERT_NOW(a_ext_quiet, clk, rst, done && !ext_update, ext_delivered == '0 && ext_source == '0)
  `CLID_ASSERT_NOW(a_soft_in_range, clk, rst, done, (soft_irq_lines & ~full) == '0)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster interrupt distributor testbench
// Drives bus reads, bus writes and source level changes into the distributor
// under several hart, source and routing settings, predicts every response
// with a behavioral copy of the register and routing state, and compares each
// response field by field in request order.
// ----------------------------------------------------------------------------
module tb_top;
  import clid_pkg::*;

  localparam logic [PRIV_W-1:0]  PRIV_USER     = 2'd0;
  localparam logic [PRIV_W-1:0]  PRIV_RESERVED = 2'd2;
  localparam logic [GROUP_W-1:0] GRP_UNMAPPED  = 4'd8;
  localparam int                 PHASES        = 6;
  localparam int                 PHASE_ITEMS   = 100;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] irq_lines;
    logic              ext_update;
    logic [IDX_W-1:0]  ext_source;
    logic [DATA_W-1:0] ext_delivered;
    logic              denied;
    logic              bad_reg;
  } dist_result_t;

  class dist_scoreboard;
    logic [DATA_W-1:0]    core_status [MAX_HARTS];
    logic [SEM_W-1:0]     sem [MAX_SEMAPHORES];
    logic [DATA_W-1:0]    indicator [MAX_SOURCES];
    logic [DATA_W-1:0]    hmask [MAX_SOURCES];
    logic [DATA_W-1:0]    delivered [MAX_SOURCES];
    logic                 levels [MAX_SOURCES];
    logic                 srw_lock;
    logic [HARTS_W-1:0]   harts;
    logic [SOURCES_W-1:0] sources;
    logic                 router;
    dist_result_t         expected_responses [$];
    int                   errors;
    int                   checked;
    int                   routed;
    int                   refused;
    int                   unmapped;

    function new();
      harts = 1;
      sources = 0;
      router = 1'b1;
      srw_lock = 1'b0;
      for (int i = 0; i < MAX_HARTS; i++) core_status[i] = '0;
      for (int i = 0; i < MAX_SEMAPHORES; i++) sem[i] = SEM_FREE;
      for (int i = 0; i < MAX_SOURCES; i++) begin
        indicator[i] = IND_RESET;
        hmask[i] = implemented_mask();
        delivered[i] = '0;
        levels[i] = 1'b0;
      end
    endfunction

    function int implemented_count();
      return (int'(harts) > MAX_HARTS) ? MAX_HARTS : int'(harts);
    endfunction

    function logic [DATA_W-1:0] implemented_mask();
      int n;
      n = implemented_count();
      return (n >= DATA_W) ? '1 : ((DATA_W'(1) << n) - DATA_W'(1));
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] v);
      case (ri)
        CFG_HARTS: begin
          harts = v[HARTS_W-1:0];
          for (int i = 0; i < MAX_SOURCES; i++) hmask[i] = implemented_mask();
        end
        CFG_SOURCES: sources = v;
        CFG_ROUTER:  router = v[0];
        default: ;
      endcase
    endfunction

    function void update_delivery(int src, inout dist_result_t r);
      logic [DATA_W-1:0] want;
      if (!router || src >= int'(sources)) return;
      want = levels[src] ? (indicator[src] & hmask[src] & implemented_mask()) : '0;
      if (want != delivered[src]) begin
        delivered[src] = want;
        r.ext_update = 1'b1;
        r.ext_source = IDX_W'(src);
        r.ext_delivered = want;
      end
    endfunction

    function void request_taken(logic [CMD_W-1:0] cmd, logic [GROUP_W-1:0] grp,
                                logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d,
                                logic [PRIV_W-1:0] priv, logic lvl);
      dist_result_t      r;
      logic [DATA_W-1:0] full;
      logic [DATA_W-1:0] nm;
      logic [SEM_W-1:0]  cur;
      logic [SEM_W-1:0]  nv;
      int                snd;
      int                rcv;
      int                n;
      int                i;
      bit                ok;
      r = '0;
      ok = 1'b1;
      full = implemented_mask();
      n = implemented_count();
      i = int'(idx);
      if (cmd == CMD_READ || cmd == CMD_WRITE) begin
        if (!(priv == PRIV_MACHINE ||
              (grp != GRP_SRW && priv == PRIV_SUPER && !srw_lock))) begin
          r.denied = 1'b1;
        end else if (cmd == CMD_READ) begin
          case (grp)
            GRP_CORE:    if (i < MAX_HARTS) r.read_data = core_status[i]; else ok = 0;
            GRP_SEM:     if (i < MAX_SEMAPHORES) r.read_data = DATA_W'(sem[i]); else ok = 0;
            GRP_IND:     r.read_data = indicator[i];
            GRP_MASK:    r.read_data = hmask[i];
            GRP_HARTS:   r.read_data = DATA_W'(harts);
            GRP_SOURCES: r.read_data = DATA_W'(sources);
            GRP_SRW:     r.read_data = DATA_W'(srw_lock);
            default:     ok = 0;
          endcase
          r.bad_reg = !ok;
        end else begin
          case (grp)
            GRP_CORE: begin
              if (i < MAX_HARTS) core_status[i] &= ~d; else ok = 0;
            end
            GRP_SEM: begin
              if (i < MAX_SEMAPHORES) begin
                cur = sem[i];
                nv = d[SEM_W-1:0];
                if (nv == SEM_FREE || cur == SEM_FREE || cur == nv) sem[i] = nv;
              end else begin
                ok = 0;
              end
            end
            GRP_ICI: begin
              snd = int'(d[31:16]);
              rcv = int'(d[15:0]);
              if (snd < n && rcv < n) core_status[rcv] |= DATA_W'(1) << snd;
            end
            GRP_IND: begin
              indicator[i] = d & full;
              update_delivery(i, r);
            end
            GRP_MASK: begin
              nm = d & full;
              if (hmask[i] == full || nm == full) begin
                hmask[i] = nm;
                update_delivery(i, r);
              end
            end
            GRP_SRW: srw_lock = d[0];
            default: ok = 0;
          endcase
          r.bad_reg = !ok;
        end
      end else if (cmd == CMD_LEVEL) begin
        if (router && i < int'(sources)) begin
          levels[i] = lvl;
          update_delivery(i, r);
        end
      end
      for (int h = 0; h < MAX_HARTS; h++)
        if (core_status[h] != '0) r.irq_lines[h] = 1'b1;
      r.irq_lines &= full;
      routed += int'(r.ext_update);
      refused += int'(r.denied);
      unmapped += int'(r.bad_reg);
      expected_responses.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    task check_result(dist_result_t got);
      dist_result_t want;
      if (expected_responses.size() == 0) begin
        report_mismatch("response with no request pending");
        return;
      end
      want = expected_responses.pop_front();
      checked++;
      compare_field("read_data", got.read_data, want.read_data);
      compare_field("soft_irq_lines", got.irq_lines, want.irq_lines);
      compare_field("ext_update", DATA_W'(got.ext_update), DATA_W'(want.ext_update));
      compare_field("ext_source", DATA_W'(got.ext_source), DATA_W'(want.ext_source));
      compare_field("ext_delivered", got.ext_delivered, want.ext_delivered);
      compare_field("access_denied", DATA_W'(got.denied), DATA_W'(want.denied));
      compare_field("bad_register", DATA_W'(got.bad_reg), DATA_W'(want.bad_reg));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      command = CMD_READ;
  logic [GROUP_W-1:0]    reg_group = GRP_CORE;
  logic [IDX_W-1:0]      item_index = '0;
  logic [DATA_W-1:0]     write_data = '0;
  logic [PRIV_W-1:0]     priv_level = PRIV_USER;
  logic                  source_level = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HARTS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  done;
  logic [DATA_W-1:0]     read_data;
  logic [DATA_W-1:0]     soft_irq_lines;
  logic                  ext_update;
  logic [IDX_W-1:0]      ext_source;
  logic [DATA_W-1:0]     ext_delivered;
  logic                  access_denied;
  logic                  bad_register;

  dist_scoreboard chk;
  int             idle_pct;
  int             settings;

  int ph_harts   [PHASES] = '{32, 1, 8, 17, 32, 5};
  int ph_sources [PHASES] = '{64, 1, 16, 64, 0, 33};
  int ph_router  [PHASES] = '{1, 1, 0, 1, 1, 1};
  int ph_idle    [PHASES] = '{9, 9, 46, 46, 0, 0};

  cluster_interrupt_distributor_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .reg_group(reg_group), .item_index(item_index),
    .write_data(write_data), .priv_level(priv_level), .source_level(source_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .read_data(read_data),
    .soft_irq_lines(soft_irq_lines), .ext_update(ext_update), .ext_source(ext_source),
    .ext_delivered(ext_delivered), .access_denied(access_denied),
    .bad_register(bad_register)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) chk.set_register(cfg_index, cfg_data);
      if (start && !busy)
        chk.request_taken(command, reg_group, item_index, write_data, priv_level,
                          source_level);
      if (done)
        chk.check_result({read_data, soft_irq_lines, ext_update, ext_source,
                          ext_delivered, access_denied, bad_register});
    end
  end

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [GROUP_W-1:0] grp,
                       input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] d,
                       input logic [PRIV_W-1:0] priv, input logic lvl);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    reg_group <= grp;
    item_index <= idx;
    write_data <= d;
    priv_level <= priv;
    source_level <= lvl;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (chk.expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input int h, input int s, input int r);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= (i == 0) ? CFG_HARTS : (i == 1) ? CFG_SOURCES : CFG_ROUTER;
      cfg_data <= (i == 0) ? CFG_DATA_W'(h) : (i == 1) ? CFG_DATA_W'(s) : CFG_DATA_W'(r);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic random_item();
    logic [CMD_W-1:0]   cmd;
    logic [GROUP_W-1:0] grp;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  d;
    logic [PRIV_W-1:0]  priv;
    int                 sel;
    int                 n;
    int                 s;
    n = chk.implemented_count();
    s = int'(chk.sources);
    sel = $urandom_range(99);
    cmd = (sel < 35) ? CMD_READ : (sel < 75) ? CMD_WRITE : CMD_LEVEL;
    sel = $urandom_range(99);
    priv = (sel < 55) ? PRIV_MACHINE : (sel < 85) ? PRIV_SUPER :
           (sel < 93) ? PRIV_USER : PRIV_RESERVED;
    sel = $urandom_range(99);
    grp = (sel < 14) ? GRP_CORE : (sel < 26) ? GRP_SEM : (sel < 42) ? GRP_ICI :
          (sel < 60) ? GRP_IND : (sel < 76) ? GRP_MASK : (sel < 80) ? GRP_HARTS :
          (sel < 84) ? GRP_SOURCES : (sel < 92) ? GRP_SRW : GRP_UNMAPPED;
    d = $urandom;
    if (cmd == CMD_LEVEL || grp == GRP_IND || grp == GRP_MASK)
      idx = IDX_W'($urandom_range((s == 0) ? 3 : (s > 63) ? 63 : s));
    else if (grp == GRP_SEM)
      idx = IDX_W'($urandom_range(7));
    else
      idx = IDX_W'($urandom_range(n - 1));
    if ($urandom_range(9) == 0) idx = IDX_W'($urandom);
    sel = $urandom_range(99);
    case (grp)
      GRP_CORE: if (sel < 50) d = DATA_W'(1) << $urandom_range(31);
      GRP_SEM: begin
        if (sel < 30) d[SEM_W-1:0] = SEM_FREE;
        else if (sel < 80) d[SEM_W-1:0] = SEM_W'($urandom_range(3));
      end
      GRP_ICI: begin
        if (sel < 80) d = {ID_W'($urandom_range(n - 1)), ID_W'($urandom_range(n - 1))};
        else if (sel < 90) d = {ID_W'($urandom_range(n + 1)), ID_W'($urandom_range(n + 1))};
      end
      GRP_MASK: if (sel < 40) d = '1;
      GRP_SRW: d[0] = (sel < 30);
      default: ;
    endcase
    issue(cmd, grp, idx, d, priv, 1'($urandom_range(1)));
  endtask

  initial begin
    chk = new();
    idle_pct = 9;
    settings = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(4, 8, 1);
    issue(CMD_READ, GRP_HARTS, 0, 0, PRIV_MACHINE, 0);
    issue(CMD_READ, GRP_SRW, 0, 0, PRIV_USER, 0);
    issue(CMD_WRITE, GRP_SRW, 0, 32'h1, PRIV_SUPER, 0);
    issue(CMD_READ, GRP_UNMAPPED, 0, 0, PRIV_MACHINE, 0);
    issue(CMD_READ, GRP_ICI, 0, 0, PRIV_MACHINE, 0);
    issue(CMD_WRITE, GRP_HARTS, 0, '1, PRIV_MACHINE, 0);
    issue(CMD_READ, GRP_CORE, 63, 0, PRIV_MACHINE, 0);
    issue(CMD_WRITE, GRP_SEM, 32, 0, PRIV_SUPER, 0);
    issue(CMD_WRITE, GRP_ICI, 0, {16'd1, 16'd2}, PRIV_MACHINE, 0);
    issue(CMD_WRITE, GRP_ICI, 0, {16'hffff, 16'd0}, PRIV_MACHINE, 0);
    issue(CMD_WRITE, GRP_CORE, 2, 32'h2, PRIV_SUPER, 0);
    issue(CMD_WRITE, GRP_SEM, 5, 32'h12, PRIV_MACHINE, 0);
    issue(CMD_WRITE, GRP_SEM, 5, 32'h34, PRIV_MACHINE, 0);
    issue(CMD_READ, GRP_SEM, 5, 0, PRIV_SUPER, 0);
    issue(CMD_WRITE, GRP_SEM, 5, '1, PRIV_MACHINE, 0);
    issue(CMD_WRITE, GRP_IND, 3, '1, PRIV_MACHINE, 0);
    issue(CMD_LEVEL, GRP_CORE, 3, 0, PRIV_USER, 1);
    issue(CMD_WRITE, GRP_MASK, 3, 32'h5, PRIV_MACHINE, 0);
    issue(CMD_WRITE, GRP_MASK, 3, 32'h2, PRIV_MACHINE, 0);
    issue(CMD_WRITE, GRP_MASK, 3, '1, PRIV_MACHINE, 0);
    issue(CMD_LEVEL, GRP_CORE, 63, 0, PRIV_USER, 1);
    issue(CMD_WRITE, GRP_SRW, 0, 32'h1, PRIV_MACHINE, 0);
    issue(CMD_READ, GRP_CORE, 0, 0, PRIV_SUPER, 0);
    issue(CMD_READ, GRP_CORE, 0, 0, PRIV_RESERVED, 0);
    issue(CMD_WRITE, GRP_SRW, 0, 32'h0, PRIV_MACHINE, 0);
    issue(CMD_LEVEL, GRP_CORE, 3, 0, PRIV_USER, 0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      configure(ph_harts[p], ph_sources[p], ph_router[p]);
      idle_pct = ph_idle[p];
      repeat (PHASE_ITEMS) random_item();
      settle();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d responses under %0d register settings: %0d delivery changes,",
             chk.checked, settings, chk.routed);
    $display("%0d refused and %0d unmapped accesses.", chk.refused, chk.unmapped);
    if (chk.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out waiting for the distributor.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
